>>> rtl/core/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
`default_nettype none

package qrs_pkg;

  // Default widths of the coefficients and of the root fraction.
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of one root on the result channel.
  localparam int OUT_W = 48;

  // Width of the root class code.
  localparam int KIND_W = 3;

  // Root class of one item.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALL     = 3'd0,
    KIND_NONE    = 3'd1,
    KIND_LINEAR  = 3'd2,
    KIND_DOUBLE  = 3'd3,
    KIND_TWO     = 3'd4,
    KIND_COMPLEX = 3'd5
  } kind_t;

endpackage

`default_nettype wire

>>> rtl/core/qrs_front.sv
// Front stages: coefficient magnitudes, products, discriminant and class.
`default_nettype none

module qrs_front import qrs_pkg::*; #(
  parameter int CW = COEF_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CW-1:0]         in_a,
  input  wire logic [CW-1:0]         in_b,
  input  wire logic [CW-1:0]         in_c,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output kind_t                      out_kind,
  output logic [2*CW+1:0]            out_rad,
  output logic [CW+FB:0]             out_base,
  output logic [CW:0]                out_den,
  output logic                       out_den_neg
);

  localparam int DW  = 2 * CW + 2;
  localparam int BW  = CW + FB + 1;
  localparam int DNW = CW + 1;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic          an1_r, bn1_r, cn1_r;
  logic [CW-1:0] am1_r, bm1_r, cm1_r;

  logic            an2_r, bn2_r, cn2_r;
  logic [CW-1:0]   am2_r, bm2_r, cm2_r;
  logic [2*CW-1:0] p2_r, q2_r;

  logic [DW-1:0]  pe, q4, d_nxt;
  logic           ac_pos, dneg_nxt;
  kind_t          kind_nxt;
  logic [CW-1:0]  mag_sel;
  logic           neg_sel;
  logic [BW-1:0]  base_mag, base_nxt;
  logic [DNW-1:0] den_nxt;
  logic           den_neg_nxt;

  kind_t          kind_r;
  logic [DW-1:0]  rad_r;
  logic [BW-1:0]  base_r;
  logic [DNW-1:0] den_r;
  logic           den_neg_r;

  // Each stage takes an item when it is empty or its item moves on.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage one: signs and magnitudes of the coefficients.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      an1_r <= in_a[CW-1];
      bn1_r <= in_b[CW-1];
      cn1_r <= in_c[CW-1];
      am1_r <= in_a[CW-1] ? (~in_a + 1'b1) : in_a;
      bm1_r <= in_b[CW-1] ? (~in_b + 1'b1) : in_b;
      cm1_r <= in_c[CW-1] ? (~in_c + 1'b1) : in_c;
    end
  end

  // Stage two: the products b*b and a*c on magnitudes.
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      an2_r <= an1_r;
      bn2_r <= bn1_r;
      cn2_r <= cn1_r;
      am2_r <= am1_r;
      bm2_r <= bm1_r;
      cm2_r <= cm1_r;
      p2_r  <= bm1_r * bm1_r;
      q2_r  <= am1_r * cm1_r;
    end
  end

  // Discriminant magnitude and sign.
  always_comb begin
    pe     = {2'b00, p2_r};
    q4     = {q2_r, 2'b00};
    ac_pos = (q2_r != '0) && (an2_r == cn2_r);
    priority if (!ac_pos) begin
      d_nxt    = pe + q4;
      dneg_nxt = 1'b0;
    end else if (q4 > pe) begin
      d_nxt    = q4 - pe;
      dneg_nxt = 1'b1;
    end else begin
      d_nxt    = pe - q4;
      dneg_nxt = 1'b0;
    end
  end

  // Root class.
  always_comb begin
    priority if (am2_r == '0 && bm2_r == '0) begin
      kind_nxt = (cm2_r == '0) ? KIND_ALL : KIND_NONE;
    end else if (am2_r == '0) begin
      kind_nxt = KIND_LINEAR;
    end else if (d_nxt == '0) begin
      kind_nxt = KIND_DOUBLE;
    end else if (dneg_nxt) begin
      kind_nxt = KIND_COMPLEX;
    end else begin
      kind_nxt = KIND_TWO;
    end
  end

  // Scaled numerator base (-c or -b) and the denominator with its sign.
  always_comb begin
    mag_sel     = (kind_nxt == KIND_LINEAR) ? cm2_r : bm2_r;
    neg_sel     = (kind_nxt == KIND_LINEAR) ? !cn2_r : !bn2_r;
    base_mag    = BW'(mag_sel) << FB;
    base_nxt    = neg_sel ? (~base_mag + 1'b1) : base_mag;
    den_nxt     = (kind_nxt == KIND_LINEAR) ? {1'b0, bm2_r} : {am2_r, 1'b0};
    den_neg_nxt = (kind_nxt == KIND_LINEAR) ? bn2_r : an2_r;
  end

  // Stage three: register toward the square root chain.
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      kind_r    <= kind_nxt;
      rad_r     <= d_nxt;
      base_r    <= base_nxt;
      den_r     <= den_nxt;
      den_neg_r <= den_neg_nxt;
    end
  end

  assign out_valid   = v3_r;
  assign out_kind    = kind_r;
  assign out_rad     = rad_r;
  assign out_base    = base_r;
  assign out_den     = den_r;
  assign out_den_neg = den_neg_r;

endmodule

`default_nettype wire

>>> rtl/core/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item.
`default_nettype none

module qrs_sqrt_cell #(
  parameter int SW     = 33,
  parameter int RW     = 66,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [RW-1:0]     in_rad,
  input  wire logic [SW+1:0]     in_rem,
  input  wire logic [SW-1:0]     in_root,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [RW-1:0]          out_rad,
  output logic [SW+1:0]          out_rem,
  output logic [SW-1:0]          out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic              valid_r;
  logic [RW-1:0]     rad_r;
  logic [SW+1:0]     rem_r;
  logic [SW-1:0]     root_r;
  logic [SIDE_W-1:0] side_r;
  logic [SW+1:0]     remx, trial;
  logic              ge;

  assign in_ready = !valid_r || out_ready;

  // Bring down the next radicand bit pair and try the trial subtrahend.
  always_comb begin
    remx  = {in_rem[SW-1:0], in_rad[RW-1 -: 2]};
    trial = {in_root, 2'b01};
    ge    = (remx >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rad_r  <= in_rad << 2;
      rem_r  <= ge ? (remx - trial) : remx;
      root_r <= {in_root[SW-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

>>> rtl/core/qrs_div_cell.sv
// One cell of the divider chain: settles one quotient bit of both roots.
`default_nettype none

module qrs_div_cell #(
  parameter int NW     = 34,
  parameter int DNW    = 17,
  parameter int SIDE_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [NW-1:0]     in_num1,
  input  wire logic [NW-1:0]     in_num2,
  input  wire logic [DNW-1:0]    in_rem1,
  input  wire logic [DNW-1:0]    in_rem2,
  input  wire logic [NW-1:0]     in_q1,
  input  wire logic [NW-1:0]     in_q2,
  input  wire logic [DNW-1:0]    in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [NW-1:0]          out_num1,
  output logic [NW-1:0]          out_num2,
  output logic [DNW-1:0]         out_rem1,
  output logic [DNW-1:0]         out_rem2,
  output logic [NW-1:0]          out_q1,
  output logic [NW-1:0]          out_q2,
  output logic [DNW-1:0]         out_den,
  output logic [SIDE_W-1:0]      out_side
);

  logic              valid_r;
  logic [NW-1:0]     num1_r, num2_r, q1_r, q2_r;
  logic [DNW-1:0]    rem1_r, rem2_r, den_r;
  logic [SIDE_W-1:0] side_r;
  logic [DNW:0]      remx1, remx2, dx, sub1, sub2;
  logic              ge1, ge2;

  assign in_ready = !valid_r || out_ready;

  // Restoring division step for both lanes against the shared denominator.
  always_comb begin
    dx    = {1'b0, in_den};
    remx1 = {in_rem1, in_num1[NW-1]};
    remx2 = {in_rem2, in_num2[NW-1]};
    ge1   = (remx1 >= dx);
    ge2   = (remx2 >= dx);
    sub1  = ge1 ? (remx1 - dx) : remx1;
    sub2  = ge2 ? (remx2 - dx) : remx2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num1_r <= in_num1 << 1;
      num2_r <= in_num2 << 1;
      rem1_r <= sub1[DNW-1:0];
      rem2_r <= sub2[DNW-1:0];
      q1_r   <= {in_q1[NW-2:0], ge1};
      q2_r   <= {in_q2[NW-2:0], ge2};
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_num1  = num1_r;
  assign out_num2  = num2_r;
  assign out_rem1  = rem1_r;
  assign out_rem2  = rem2_r;
  assign out_q1    = q1_r;
  assign out_q2    = q2_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

>>> rtl/core/quadratic_root_solver.sv
// Top level of the quadratic root solver: front stages, root and divider chains.
`default_nettype none

// Solves a*x^2 + b*x + c = 0 for one coefficient set per item and returns the
// root class with two signed roots of FRAC_BITS fraction bits, truncated
// toward zero and saturated to 48 bits. The block is fully pipelined and
// takes one item every cycle while in_stall is low. Each item passes
// through three front stages, one square root cell per root bit
// (COEF_WIDTH + FRAC_BITS + 1), a numerator stage, one divider cell per
// quotient bit (COEF_WIDTH + FRAC_BITS + 2) and the output register.
// Every stage holds its item under stall and takes a new one as soon as
// it empties, so gaps in the stream close up while the output waits.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COEF_WIDTH-1:0] in_coef_a,
  input  wire logic [COEF_WIDTH-1:0] in_coef_b,
  input  wire logic [COEF_WIDTH-1:0] in_coef_c,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [KIND_W-1:0]          out_root_kind,
  output logic [OUT_W-1:0]           out_root_first,
  output logic [OUT_W-1:0]           out_root_second
);

  localparam int CW      = COEF_WIDTH;
  localparam int FB      = FRAC_BITS;
  localparam int DW      = 2 * CW + 2;
  localparam int RW      = DW + 2 * FB;
  localparam int SW      = RW / 2;
  localparam int BW      = CW + FB + 1;
  localparam int DNW     = CW + 1;
  localparam int NW      = CW + FB + 2;
  localparam int NSW     = NW + 1;
  localparam int SQ_SIDE = KIND_W + BW + DNW + 1;
  localparam int DV_SIDE = KIND_W + 3;
  localparam int QX      = (NW > OUT_W) ? NW : OUT_W;

  // Front stages.
  logic           front_ready, front_valid;
  kind_t          front_kind;
  logic [DW-1:0]  front_rad;
  logic [BW-1:0]  front_base;
  logic [DNW-1:0] front_den;
  logic           front_den_neg;

  // Square root chain.
  logic               sq_valid [0:SW];
  logic               sq_ready [0:SW];
  logic [RW-1:0]      sq_rad   [0:SW];
  logic [SW+1:0]      sq_rem   [0:SW];
  logic [SW-1:0]      sq_root  [0:SW];
  logic [SQ_SIDE-1:0] sq_side  [0:SW];

  // Numerator stage.
  logic                pv_r, p_ready;
  logic [NW-1:0]       pn1_r, pn2_r;
  logic [DNW-1:0]      pden_r;
  logic [DV_SIDE-1:0]  pside_r;
  logic [KIND_W-1:0]   sq_kind;
  logic [BW-1:0]       sq_base;
  logic [DNW-1:0]      sq_den;
  logic                sq_den_neg;
  logic [NSW-1:0]      base_ext, s_ext, n1, n2, n1_mag, n2_mag;

  // Divider chain.
  logic               dv_valid [0:NW];
  logic               dv_ready [0:NW];
  logic [NW-1:0]      dv_num1  [0:NW];
  logic [NW-1:0]      dv_num2  [0:NW];
  logic [DNW-1:0]     dv_rem1  [0:NW];
  logic [DNW-1:0]     dv_rem2  [0:NW];
  logic [NW-1:0]      dv_q1    [0:NW];
  logic [NW-1:0]      dv_q2    [0:NW];
  logic [DNW-1:0]     dv_den   [0:NW];
  logic [DV_SIDE-1:0] dv_side  [0:NW];

  // Output stage.
  logic              out_ready;
  logic [KIND_W-1:0] fin_kind;
  logic              fin_neg1, fin_neg2, fin_den_neg;
  logic [OUT_W-1:0]  r1_nxt, r2_nxt;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [OUT_W-1:0]  out_first_r, out_second_r;

  // Signed, saturated root from a quotient magnitude and its sign.
  function automatic logic [OUT_W-1:0] sat_root(input logic [NW-1:0] q, input logic neg);
    logic [QX-1:0]    qx;
    logic [QX-1:0]    lim_pos;
    logic [QX-1:0]    lim_neg;
    logic [OUT_W-1:0] low;
    qx      = QX'(q);
    lim_pos = QX'({(OUT_W-1){1'b1}});
    lim_neg = QX'({1'b1, {(OUT_W-1){1'b0}}});
    low     = qx[OUT_W-1:0];
    if (neg) begin
      sat_root = (qx > lim_neg) ? {1'b1, {(OUT_W-1){1'b0}}} : (~low + 1'b1);
    end else begin
      sat_root = (qx > lim_pos) ? {1'b0, {(OUT_W-1){1'b1}}} : low;
    end
  endfunction

  qrs_front #(
    .CW (CW),
    .FB (FB)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (front_ready),
    .in_a        (in_coef_a),
    .in_b        (in_coef_b),
    .in_c        (in_coef_c),
    .out_valid   (front_valid),
    .out_ready   (sq_ready[0]),
    .out_kind    (front_kind),
    .out_rad     (front_rad),
    .out_base    (front_base),
    .out_den     (front_den),
    .out_den_neg (front_den_neg)
  );

  assign in_stall = !front_ready;

  // Head of the square root chain: radicand scaled by the fraction bits.
  assign sq_valid[0] = front_valid;
  assign sq_rad[0]   = RW'(front_rad) << (2 * FB);
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = {front_kind, front_base, front_den, front_den_neg};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .SW     (SW),
      .RW     (RW),
      .SIDE_W (SQ_SIDE)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_side   (sq_side[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_side  (sq_side[i+1])
    );
  end

  // Numerators of both roots once the square root is known.
  assign {sq_kind, sq_base, sq_den, sq_den_neg} = sq_side[SW];

  always_comb begin
    base_ext = {{(NSW-BW){sq_base[BW-1]}}, sq_base};
    s_ext    = NSW'(sq_root[SW]);
    unique case (sq_kind)
      KIND_LINEAR, KIND_DOUBLE: begin
        n1 = base_ext;
        n2 = '0;
      end
      KIND_TWO: begin
        n1 = base_ext + s_ext;
        n2 = base_ext - s_ext;
      end
      KIND_COMPLEX: begin
        n1 = base_ext;
        n2 = s_ext;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    n1_mag = n1[NSW-1] ? (~n1 + 1'b1) : n1;
    n2_mag = n2[NSW-1] ? (~n2 + 1'b1) : n2;
  end

  assign p_ready      = !pv_r || dv_ready[0];
  assign sq_ready[SW] = p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (p_ready) begin
      pv_r <= sq_valid[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && sq_valid[SW]) begin
      pn1_r   <= n1_mag[NW-1:0];
      pn2_r   <= n2_mag[NW-1:0];
      pden_r  <= sq_den;
      pside_r <= {sq_kind, n1[NSW-1], n2[NSW-1], sq_den_neg};
    end
  end

  // Divider chain.
  assign dv_valid[0] = pv_r;
  assign dv_num1[0]  = pn1_r;
  assign dv_num2[0]  = pn2_r;
  assign dv_rem1[0]  = '0;
  assign dv_rem2[0]  = '0;
  assign dv_q1[0]    = '0;
  assign dv_q2[0]    = '0;
  assign dv_den[0]   = pden_r;
  assign dv_side[0]  = pside_r;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(
      .NW     (NW),
      .DNW    (DNW),
      .SIDE_W (DV_SIDE)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[j]),
      .in_ready  (dv_ready[j]),
      .in_num1   (dv_num1[j]),
      .in_num2   (dv_num2[j]),
      .in_rem1   (dv_rem1[j]),
      .in_rem2   (dv_rem2[j]),
      .in_q1     (dv_q1[j]),
      .in_q2     (dv_q2[j]),
      .in_den    (dv_den[j]),
      .in_side   (dv_side[j]),
      .out_valid (dv_valid[j+1]),
      .out_ready (dv_ready[j+1]),
      .out_num1  (dv_num1[j+1]),
      .out_num2  (dv_num2[j+1]),
      .out_rem1  (dv_rem1[j+1]),
      .out_rem2  (dv_rem2[j+1]),
      .out_q1    (dv_q1[j+1]),
      .out_q2    (dv_q2[j+1]),
      .out_den   (dv_den[j+1]),
      .out_side  (dv_side[j+1])
    );
  end

  // Signs, saturation and zeroing of unused roots.
  assign {fin_kind, fin_neg1, fin_neg2, fin_den_neg} = dv_side[NW];

  always_comb begin
    unique case (fin_kind)
      KIND_LINEAR, KIND_DOUBLE: begin
        r1_nxt = sat_root(dv_q1[NW], fin_neg1 ^ fin_den_neg);
        r2_nxt = '0;
      end
      KIND_TWO, KIND_COMPLEX: begin
        r1_nxt = sat_root(dv_q1[NW], fin_neg1 ^ fin_den_neg);
        r2_nxt = sat_root(dv_q2[NW], fin_neg2 ^ fin_den_neg);
      end
      default: begin
        r1_nxt = '0;
        r2_nxt = '0;
      end
    endcase
  end

  assign out_ready    = !out_valid_r || !out_stall;
  assign dv_ready[NW] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dv_valid[NW]) begin
      out_kind_r   <= fin_kind;
      out_first_r  <= r1_nxt;
      out_second_r <= r2_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_kind   = out_kind_r;
  assign out_root_first  = out_first_r;
  assign out_root_second = out_second_r;

  // With the output register empty, every stage is free to move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // Classes without roots report zero roots.
  a_no_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_ALL || out_kind_r == KIND_NONE))
      |-> (out_first_r == '0 && out_second_r == '0))
    else $error("roots reported for a class without roots");

  // Single-root classes leave the second root at zero.
  a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_LINEAR || out_kind_r == KIND_DOUBLE))
      |-> (out_second_r == '0))
    else $error("second root set for a single-root class");

  // An item leaving the divider chain is taken by a free output register.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid[NW] && out_ready) |=> out_valid_r)
    else $error("finished item lost at the output register");

endmodule

`default_nettype wire
